/* rtl/pfe_pkg.sv */
// shared types and codes for the pipe fifo with end counts
`default_nettype none

package pfe_pkg;

    localparam logic [2:0] FUNC_OPEN  = 3'd0;
    localparam logic [2:0] FUNC_CLOSE = 3'd1;
    localparam logic [2:0] FUNC_READ  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_POLL  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_AGAIN    = 3'd1;
    localparam logic [2:0] ST_EOF      = 3'd2;
    localparam logic [2:0] ST_PIPE     = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;

    localparam logic [3:0] POLL_IN  = 4'b0001;
    localparam logic [3:0] POLL_OUT = 4'b0010;
    localparam logic [3:0] POLL_HUP = 4'b0100;
    localparam logic [3:0] POLL_ERR = 4'b1000;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 32;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ring_ctl;

    typedef struct packed {
        logic [12:0] bytes_used;
        logic [3:0]  poll_flags;
        logic [7:0]  read_data;
        logic [2:0]  status;
    } t_result;

endpackage

`default_nettype wire

/* rtl/pfe_ring.sv */
// byte ring storage, one write and one registered read port
`default_nettype none

module pfe_ring #(
    parameter int unsigned FIFO_DEPTH = 4096,
    parameter int unsigned AW         = 12
) (
    input  wire logic               i_clk,
    input  wire pfe_pkg::t_ring_ctl i_ctl,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [7:0]         i_wr_data,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic [7:0]              o_rd_data
);

    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/pfe_ctrl.sv */
// pointer, end count and release state with per-operation update
`default_nettype none

module pfe_ctrl #(
    parameter int unsigned FIFO_DEPTH = 4096,
    parameter int unsigned COUNT_BITS = 8,
    parameter int unsigned AW         = 12,
    parameter int unsigned PW         = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_exec,
    input  wire logic [2:0]         i_func,
    input  wire logic               i_which_end,
    input  wire logic [7:0]         i_write_data,
    input  wire logic [3:0]         i_poll_mask,
    input  wire logic [7:0]         i_ring_rd_data,
    output pfe_pkg::t_ring_ctl      o_ring_ctl,
    output logic [AW-1:0]           o_ring_wr_addr,
    output logic [7:0]              o_ring_wr_data,
    output logic [AW-1:0]           o_ring_rd_addr,
    output pfe_pkg::t_result        o_result
);

    localparam logic [PW:0]         SPAN    = (PW+1)'(2 * FIFO_DEPTH);
    localparam logic [PW-1:0]       PTR_TOP = PW'(2 * FIFO_DEPTH - 1);
    localparam logic [PW-1:0]       DEPTH_P = PW'(FIFO_DEPTH);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [2:0]            r_func;
    logic                  r_wend;
    logic [7:0]            r_wdata;
    logic [3:0]            r_mask;

    logic [PW-1:0]         r_wp, n_wp;
    logic [PW-1:0]         r_rp, n_rp;
    logic [COUNT_BITS-1:0] r_rc, n_rc;
    logic [COUNT_BITS-1:0] r_wc, n_wc;
    logic                  r_rel, n_rel;

    logic [PW:0]           diff;
    logic [PW-1:0]         held;
    logic [PW-1:0]         held_after;
    logic [PW+12:0]        held_ext;
    logic                  empty;
    logic                  full;
    logic                  do_push;
    logic                  do_pop;
    logic [3:0]            pflags;
    pfe_pkg::t_result      res;

    function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
        return s[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PTR_TOP) ? '0 : (p + PW'(1));
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_func  <= i_func;
            r_wend  <= i_which_end;
            r_wdata <= i_write_data;
            r_mask  <= i_poll_mask;
        end
    end

    assign diff  = (r_wp >= r_rp) ? ({1'b0, r_wp} - {1'b0, r_rp})
                                  : ({1'b0, r_wp} + SPAN - {1'b0, r_rp});
    assign held  = diff[PW-1:0];
    assign empty = (held == '0);
    assign full  = (held >= DEPTH_P);

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_rc    = r_rc;
        n_wc    = r_wc;
        n_rel   = r_rel;
        do_push = 1'b0;
        do_pop  = 1'b0;
        pflags  = '0;
        res.status     = pfe_pkg::ST_OK;
        res.read_data  = '0;
        res.poll_flags = '0;
        if (r_rel) begin
            res.status = pfe_pkg::ST_RELEASED;
            if (r_func == pfe_pkg::FUNC_POLL) begin
                res.poll_flags = pfe_pkg::POLL_ERR;
            end
        end else begin
            case (r_func)
                pfe_pkg::FUNC_OPEN: begin
                    if (r_wend) begin
                        if (r_wc != CNT_MAX) n_wc = r_wc + COUNT_BITS'(1);
                    end else begin
                        if (r_rc != CNT_MAX) n_rc = r_rc + COUNT_BITS'(1);
                    end
                end
                pfe_pkg::FUNC_CLOSE: begin
                    if (r_wend) begin
                        if (r_wc != '0) n_wc = r_wc - COUNT_BITS'(1);
                    end else begin
                        if (r_rc != '0) n_rc = r_rc - COUNT_BITS'(1);
                    end
                    if ((n_rc == '0) && (n_wc == '0)) n_rel = 1'b1;
                end
                pfe_pkg::FUNC_READ: begin
                    if (!empty) begin
                        do_pop        = 1'b1;
                        res.read_data = i_ring_rd_data;
                        n_rp          = advance(r_rp);
                    end else begin
                        res.status = (r_wc == '0) ? pfe_pkg::ST_EOF : pfe_pkg::ST_AGAIN;
                    end
                end
                pfe_pkg::FUNC_WRITE: begin
                    if (r_rc == '0) begin
                        res.status = pfe_pkg::ST_PIPE;
                    end else if (full) begin
                        res.status = pfe_pkg::ST_AGAIN;
                    end else begin
                        do_push = 1'b1;
                        n_wp    = advance(r_wp);
                    end
                end
                pfe_pkg::FUNC_POLL: begin
                    if (!r_wend) begin
                        if (!empty || (r_wc == '0)) pflags = pflags | pfe_pkg::POLL_IN;
                        if (r_wc == '0)             pflags = pflags | pfe_pkg::POLL_HUP;
                    end else begin
                        if (!full || (r_rc == '0))  pflags = pflags | pfe_pkg::POLL_OUT;
                        if (r_rc == '0)             pflags = pflags | pfe_pkg::POLL_ERR;
                    end
                    res.poll_flags = pflags & r_mask;
                end
                default: begin
                end
            endcase
        end
        held_after = held + PW'(do_push) - PW'(do_pop);
        held_ext   = {13'b0, held_after};
        res.bytes_used = held_ext[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_rc  <= COUNT_BITS'(1);
            r_wc  <= COUNT_BITS'(1);
            r_rel <= 1'b0;
        end else if (i_exec) begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_rc  <= n_rc;
            r_wc  <= n_wc;
            r_rel <= n_rel;
        end
    end

    assign o_ring_ctl.rd_en = i_start;
    assign o_ring_ctl.wr_en = i_exec && do_push;
    assign o_ring_rd_addr   = slot(r_rp);
    assign o_ring_wr_addr   = slot(r_wp);
    assign o_ring_wr_data   = r_wdata;
    assign o_result         = res;

endmodule

`default_nettype wire

/* rtl/pipe_fifo_with_end_counts.sv */
// top level of the pipe fifo with end counts
// a result is registered into the output once its transfer is accepted and its ring read done,
// later while the output holds an unaccepted result
// no new item is taken while one is in flight: each item's ring read precedes its update of
// pointers and counts, and the next transfer is accepted only once that update is done
// reset: pointers zero, both end counts one, released mark clear;
// ring contents are left as they are and only written bytes are read back
`default_nettype none

module pipe_fifo_with_end_counts #(
    parameter int unsigned FIFO_DEPTH = 4096,
    parameter int unsigned COUNT_BITS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // func[2:0], which_end[3], write_data[11:4], poll_mask[15:12]
    input  wire logic [pfe_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status[2:0], read_data[10:3], poll_flags[14:11], bytes_used[27:15], zero pad
    output logic [pfe_pkg::OUT_DATA_W-1:0]        m_tdata
);

    localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned PW = $clog2(2 * FIFO_DEPTH);

    logic                               r_busy;
    logic                               r_m_valid;
    logic [pfe_pkg::OUT_DATA_W-1:0]     r_m_data;
    logic                               accept;
    logic                               exec;
    pfe_pkg::t_ring_ctl                 ring_ctl;
    logic [AW-1:0]                      ring_wr_addr;
    logic [AW-1:0]                      ring_rd_addr;
    logic [7:0]                         ring_wr_data;
    logic [7:0]                         ring_rd_data;
    pfe_pkg::t_result                   result;

    assign s_tready = i_rst_n && !r_busy;
    assign accept   = s_tvalid && s_tready;
    assign exec     = r_busy && (!r_m_valid || m_tready);

    pfe_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW),
        .PW         (PW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (accept),
        .i_exec         (exec),
        .i_func         (s_tdata[2:0]),
        .i_which_end    (s_tdata[3]),
        .i_write_data   (s_tdata[11:4]),
        .i_poll_mask    (s_tdata[15:12]),
        .i_ring_rd_data (ring_rd_data),
        .o_ring_ctl     (ring_ctl),
        .o_ring_wr_addr (ring_wr_addr),
        .o_ring_wr_data (ring_wr_data),
        .o_ring_rd_addr (ring_rd_addr),
        .o_result       (result)
    );

    pfe_ring #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_ctl     (ring_ctl),
        .i_wr_addr (ring_wr_addr),
        .i_wr_data (ring_wr_data),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_m_data <= {4'b0, result.bytes_used, result.poll_flags,
                         result.read_data, result.status};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

`default_nettype wire

/* tb/tb_pipe_fifo_with_end_counts.sv */
// self-checking bench, pipe fifo with end counts: directed rows, count sweep, random, release
module tb_pipe_fifo_with_end_counts;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        END_READ       = 1'b0;
    localparam logic        END_WRITE      = 1'b1;
    localparam logic [2:0]  FUNC_SPARE_LO  = 3'd5;
    localparam logic [2:0]  FUNC_SPARE_MID = 3'd6;
    localparam logic [2:0]  FUNC_SPARE_HI  = 3'd7;
    localparam logic [12:0] RING_DEPTH     = 13'd4096;
    localparam logic [7:0]  COUNT_MAX      = 8'hFF;
    localparam int          RANDOM_PER_PHASE = 150;

    localparam int unsigned SRC_GAP_PCT [4]  = '{0, 71, 0, 33};
    localparam int unsigned SINK_GAP_PCT [4] = '{0, 0, 71, 33};

    // s_tdata layout, lowest bits first: func, which_end, write_data, poll_mask
    typedef struct packed {
        logic [3:0] poll_mask;
        logic [7:0] write_data;
        logic       which_end;
        logic [2:0] func;
    } t_pipe_op;

    typedef struct {
        t_pipe_op         op;
        bit               known;
        pfe_pkg::t_result want;
    } t_directed_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [pfe_pkg::IN_DATA_W-1:0]    s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [pfe_pkg::OUT_DATA_W-1:0]   m_tdata;

    // pipe state as the block should hold it
    logic [7:0]  ring_bytes [0:4095];
    logic [12:0] wr_ptr;
    logic [12:0] rd_ptr;
    logic [7:0]  reader_ends;
    logic [7:0]  writer_ends;
    logic        is_released;

    pfe_pkg::t_result pending_results [$];
    t_directed_row    directed_ops [$];
    int               mismatch_count = 0;
    int unsigned      src_idle_pct = 0;
    int unsigned      sink_stall_pct = 0;
    int               sink_hold_left = 0;

    pipe_fifo_with_end_counts #(
        .FIFO_DEPTH(4096),
        .COUNT_BITS(8)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [12:0] fifo_fill();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic void reset_pipe_model();
        foreach (ring_bytes[k]) ring_bytes[k] = 8'h00;
        wr_ptr = '0;
        rd_ptr = '0;
        reader_ends = 8'd1;
        writer_ends = 8'd1;
        is_released = 1'b0;
    endfunction

    function automatic pfe_pkg::t_result apply_pipe_op(input t_pipe_op op);
        pfe_pkg::t_result res;
        logic [12:0]      fill;
        logic [3:0]       ev;
        res = '0;
        ev = '0;
        fill = fifo_fill();
        if (is_released) begin
            res.status = pfe_pkg::ST_RELEASED;
            if (op.func == pfe_pkg::FUNC_POLL) res.poll_flags = pfe_pkg::POLL_ERR;
        end else begin
            case (op.func)
                pfe_pkg::FUNC_OPEN: begin
                    if (op.which_end == END_WRITE) begin
                        if (writer_ends != COUNT_MAX) writer_ends++;
                    end else begin
                        if (reader_ends != COUNT_MAX) reader_ends++;
                    end
                end
                pfe_pkg::FUNC_CLOSE: begin
                    if (op.which_end == END_WRITE) begin
                        if (writer_ends != 0) writer_ends--;
                    end else begin
                        if (reader_ends != 0) reader_ends--;
                    end
                    if (reader_ends == 0 && writer_ends == 0) is_released = 1'b1;
                end
                pfe_pkg::FUNC_READ: begin
                    if (fill != 0) begin
                        res.read_data = ring_bytes[rd_ptr[11:0]];
                        rd_ptr = rd_ptr + 13'd1;
                    end else begin
                        res.status = (writer_ends == 0) ? pfe_pkg::ST_EOF
                                                        : pfe_pkg::ST_AGAIN;
                    end
                end
                pfe_pkg::FUNC_WRITE: begin
                    if (reader_ends == 0) begin
                        res.status = pfe_pkg::ST_PIPE;
                    end else if (fill >= RING_DEPTH) begin
                        res.status = pfe_pkg::ST_AGAIN;
                    end else begin
                        ring_bytes[wr_ptr[11:0]] = op.write_data;
                        wr_ptr = wr_ptr + 13'd1;
                    end
                end
                pfe_pkg::FUNC_POLL: begin
                    if (op.which_end == END_READ) begin
                        if (fill != 0 || writer_ends == 0) ev |= pfe_pkg::POLL_IN;
                        if (writer_ends == 0) ev |= pfe_pkg::POLL_HUP;
                    end else begin
                        if (fill < RING_DEPTH || reader_ends == 0) ev |= pfe_pkg::POLL_OUT;
                        if (reader_ends == 0) ev |= pfe_pkg::POLL_ERR;
                    end
                    res.poll_flags = ev & op.poll_mask;
                end
                default: ;
            endcase
        end
        res.bytes_used = fifo_fill();
        return res;
    endfunction

    function automatic t_pipe_op make_op(input logic [2:0] func, input logic which_end,
                                         input logic [7:0] data, input logic [3:0] mask);
        t_pipe_op op;
        op.func = func;
        op.which_end = which_end;
        op.write_data = data;
        op.poll_mask = mask;
        return op;
    endfunction

    function automatic void add_row(input t_pipe_op op, input bit known, input logic [2:0] st,
                                    input logic [7:0] rd, input logic [3:0] fl,
                                    input logic [12:0] used);
        t_directed_row row;
        row.op = op;
        row.known = known;
        row.want.status = st;
        row.want.read_data = rd;
        row.want.poll_flags = fl;
        row.want.bytes_used = used;
        directed_ops.push_back(row);
    endfunction

    // random operation that never closes the last open end
    function automatic t_pipe_op random_op();
        t_pipe_op    op;
        int unsigned pick;
        logic [7:0]  own;
        logic [7:0]  other;
        op.write_data = 8'($urandom);
        op.poll_mask = 4'($urandom);
        op.which_end = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 36) op.func = pfe_pkg::FUNC_WRITE;
        else if (pick < 70) op.func = pfe_pkg::FUNC_READ;
        else if (pick < 84) op.func = pfe_pkg::FUNC_POLL;
        else if (pick < 91) op.func = pfe_pkg::FUNC_OPEN;
        else if (pick < 97) op.func = pfe_pkg::FUNC_CLOSE;
        else op.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
        if (op.func == pfe_pkg::FUNC_CLOSE) begin
            own = (op.which_end == END_WRITE) ? writer_ends : reader_ends;
            other = (op.which_end == END_WRITE) ? reader_ends : writer_ends;
            if (own <= 8'd1 && other == 0) begin
                op.func = pfe_pkg::FUNC_OPEN;
                op.which_end = ~op.which_end;
            end
        end
        return op;
    endfunction

    task automatic send_op(input t_pipe_op op, input bit known = 1'b0,
                           input pfe_pkg::t_result want = '0);
        bit               done;
        pfe_pkg::t_result predicted;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            if ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= op;
                do @(posedge i_clk); while (!s_tready);
                done = 1'b1;
            end
        end
        predicted = apply_pipe_op(op);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // push the count of one end to saturation, down to zero, then back to one
    task automatic sweep_end_count(input logic which);
        repeat (256) send_op(make_op(pfe_pkg::FUNC_OPEN, which, 8'($urandom), 4'($urandom)));
        repeat (256) send_op(make_op(pfe_pkg::FUNC_CLOSE, which, 8'($urandom), 4'($urandom)));
        send_op(make_op(pfe_pkg::FUNC_OPEN, which, 8'($urandom), 4'($urandom)));
    endtask

    function automatic void check_field(input string name, input logic [12:0] want,
                                        input logic [12:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        pfe_pkg::t_result got;
        pfe_pkg::t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[27:0];
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, got %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 13'(want.status), 13'(got.status));
                check_field("read_data", 13'(want.read_data), 13'(got.read_data));
                check_field("poll_flags", 13'(want.poll_flags), 13'(got.poll_flags));
                check_field("bytes_used", want.bytes_used, got.bytes_used);
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        reset_pipe_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(make_op(pfe_pkg::FUNC_READ, END_READ, 8'h00, 4'hF), 1'b1,
                pfe_pkg::ST_AGAIN, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_READ, 8'h00, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_WRITE, 8'hFF, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, pfe_pkg::POLL_OUT, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_WRITE, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd1);
        add_row(make_op(pfe_pkg::FUNC_WRITE, END_READ, 8'hFF, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd2);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_READ, 8'h00, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, pfe_pkg::POLL_IN, 13'd2);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd2);
        add_row(make_op(pfe_pkg::FUNC_READ, END_WRITE, 8'hFF, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd1);
        add_row(make_op(pfe_pkg::FUNC_READ, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'hFF, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_WRITE, END_WRITE, 8'hA5, 4'h5), 1'b0,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_CLOSE, END_WRITE, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd1);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_READ, 8'h00, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, pfe_pkg::POLL_IN | pfe_pkg::POLL_HUP, 13'd1);
        add_row(make_op(pfe_pkg::FUNC_READ, END_READ, 8'h00, 4'h0), 1'b0,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_READ, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_EOF, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_READ, 8'h00, pfe_pkg::POLL_HUP), 1'b1,
                pfe_pkg::ST_OK, 8'h00, pfe_pkg::POLL_HUP, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_OPEN, END_WRITE, 8'h00, 4'h0), 1'b0,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_CLOSE, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_CLOSE, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_WRITE, END_READ, 8'h5A, 4'h0), 1'b1,
                pfe_pkg::ST_PIPE, 8'h00, 4'h0, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_WRITE, 8'h00, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, pfe_pkg::POLL_OUT | pfe_pkg::POLL_ERR, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_POLL, END_WRITE, 8'h00, pfe_pkg::POLL_ERR), 1'b1,
                pfe_pkg::ST_OK, 8'h00, pfe_pkg::POLL_ERR, 13'd0);
        add_row(make_op(pfe_pkg::FUNC_OPEN, END_READ, 8'h00, 4'h0), 1'b0,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(FUNC_SPARE_LO, END_WRITE, 8'hFF, 4'hF), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(FUNC_SPARE_HI, END_READ, 8'h00, 4'h0), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);
        add_row(make_op(FUNC_SPARE_MID, END_WRITE, 8'h3C, 4'hA), 1'b1,
                pfe_pkg::ST_OK, 8'h00, 4'h0, 13'd0);

        foreach (directed_ops[k])
            send_op(directed_ops[k].op, directed_ops[k].known, directed_ops[k].want);

        sweep_end_count(END_READ);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = SRC_GAP_PCT[ph];
            sink_stall_pct = SINK_GAP_PCT[ph];
            // long sink hold-off so the block backs up into its input
            if (ph == 0) sink_hold_left = 300;
            repeat (RANDOM_PER_PHASE) send_op(random_op());
            wait_drained();
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (3) send_op(make_op(pfe_pkg::FUNC_WRITE, 1'($urandom), 8'($urandom),
                                   4'($urandom)));
        while (reader_ends != 0)
            send_op(make_op(pfe_pkg::FUNC_CLOSE, END_READ, 8'($urandom), 4'($urandom)));
        while (writer_ends != 0)
            send_op(make_op(pfe_pkg::FUNC_CLOSE, END_WRITE, 8'($urandom), 4'($urandom)));
        send_op(make_op(pfe_pkg::FUNC_POLL, END_READ, 8'($urandom), 4'h0));
        repeat (2) begin
            for (int f = 0; f < 8; f++)
                send_op(make_op(3'(f), 1'($urandom), 8'($urandom), 4'($urandom)));
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
